// File: rtl/core/clamped_3x3_gaussian_blur_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clamped 3x3 blur
// Concurrent checks with a synchronous active-low reset as the disable term.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_3X3_GAUSSIAN_BLUR_ASSERT_SVH
`define CLAMPED_3X3_GAUSSIAN_BLUR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GB_CHECK_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GB_CHECK_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gblur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_pkg
// Shared constants, register and result codes, and the per-sample tag.
// ----------------------------------------------------------------------------
package gblur_pkg;

  localparam int CFG_W            = 11;
  localparam int CFG_IDX_W        = 2;
  localparam int ROW_LIMIT        = 1024;
  localparam int ROW_W            = 10;
  localparam int IDX_W            = 20;
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int FRAME_WIDTH_RST  = 1024;
  localparam int FRAME_HEIGHT_RST = 1024;
  localparam int ROUND_BIAS       = 8;
  localparam int NORM_SHIFT       = 4;
  localparam int NUM_KINDS        = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MIRROR       = 2'd2
  } cfg_reg_t;

  // Results of one sample, in emission order.
  typedef enum logic [1:0] {
    RES_UP_LEFT  = 2'd0,  // pixel (c-1, r-1)
    RES_UP_HERE  = 2'd1,  // pixel (c,   r-1)
    RES_LOW_LEFT = 2'd2,  // pixel (c-1, r)
    RES_LOW_HERE = 2'd3   // pixel (c,   r)
  } res_kind_t;

  typedef struct packed {
    logic             col_first;
    logic             col_is1;
    logic             col_last;
    logic             row_first;
    logic             row_is1;
    logic             row_last;
    logic [IDX_W-1:0] pos;
  } sample_tag_t;

endpackage

// File: rtl/core/gblur_linebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_linebuf
// Two row stores with registered reads and a bypass for same-address writes.
// ----------------------------------------------------------------------------
module gblur_linebuf #(
  parameter int DEPTH  = gblur_pkg::DEF_MAX_WIDTH,
  parameter int DATA_W = gblur_pkg::DEF_SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic signed [DATA_W-1:0]   wr_old,
  input  logic signed [DATA_W-1:0]   wr_new,
  output logic signed [DATA_W-1:0]   rd_old,
  output logic signed [DATA_W-1:0]   rd_new
);
  import gblur_pkg::*;

  logic signed [DATA_W-1:0] older_mem [DEPTH];
  logic signed [DATA_W-1:0] newer_mem [DEPTH];
  logic signed [DATA_W-1:0] older_q_r;
  logic signed [DATA_W-1:0] newer_q_r;
  logic signed [DATA_W-1:0] byp_old_r;
  logic signed [DATA_W-1:0] byp_new_r;
  logic                     byp_r;

  // A column rotates: the newer row moves to the older store, the sample
  // becomes the newer row.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_old;
      newer_mem[wr_addr] <= wr_new;
    end
    if (rd_en) begin
      older_q_r <= older_mem[rd_addr];
      newer_q_r <= newer_mem[rd_addr];
      byp_old_r <= wr_old;
      byp_new_r <= wr_new;
    end
  end

  // The memory returns the value from before a write in the same cycle, so
  // a read that collides with a write takes the written data instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_old = byp_r ? byp_old_r : older_q_r;
  assign rd_new = byp_r ? byp_new_r : newer_q_r;

endmodule

// File: rtl/core/gblur_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_raster
// Column, row and linear position counters of the incoming raster.
// ----------------------------------------------------------------------------
module gblur_raster #(
  parameter int MAX_WIDTH = gblur_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic                          step,
  input  logic [gblur_pkg::CFG_W-1:0]   w_eff,
  input  logic [gblur_pkg::CFG_W-1:0]   h_eff,
  output logic [$clog2(MAX_WIDTH)-1:0]  col,
  output gblur_pkg::sample_tag_t        tag
);
  import gblur_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;

  always_comb begin
    tag.col_first = (col_r == '0);
    tag.col_is1   = (col_r == COL_W'(1));
    tag.col_last  = (32'(col_r) == 32'(w_eff) - 32'd1);
    tag.row_first = (row_r == '0);
    tag.row_is1   = (row_r == ROW_W'(1));
    tag.row_last  = (32'(row_r) == 32'(h_eff) - 32'd1);
    tag.pos       = pos_r;
  end

  assign col = col_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      pos_nxt = '0;
    end else if (step) begin
      pos_nxt = pos_r + IDX_W'(1);
      if (tag.col_last) begin
        col_nxt = '0;
        if (tag.row_last) begin
          row_nxt = '0;
          pos_nxt = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

// File: rtl/core/gblur_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gblur_kernel
// 1-2-1 binomial kernel over the window with edge clamping and rounding.
// ----------------------------------------------------------------------------
module gblur_kernel #(
  parameter int SAMPLE_BITS = gblur_pkg::DEF_SAMPLE_BITS
) (
  input  logic signed [SAMPLE_BITS-1:0] win [3][3],
  input  gblur_pkg::res_kind_t          kind,
  input  gblur_pkg::sample_tag_t        tag,
  output logic signed [SAMPLE_BITS-1:0] blurred
);
  import gblur_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 4;

  logic [1:0]              lc, cc, rc;
  logic [1:0]              rsel [3];
  logic signed [SUM_W-1:0] hsum [3];
  logic signed [SUM_W-1:0] total;

  // Window column 2 is the current column c, row 2 the current row r.
  // Neighbors outside the image fold back onto the edge sample.
  always_comb begin
    case (kind)
      RES_UP_LEFT, RES_LOW_LEFT: begin
        lc = tag.col_is1 ? 2'd1 : 2'd0;
        cc = 2'd1;
        rc = 2'd2;
      end
      RES_UP_HERE, RES_LOW_HERE: begin
        lc = tag.col_first ? 2'd2 : 2'd1;
        cc = 2'd2;
        rc = 2'd2;
      end
      default: begin
        lc = 2'd0;
        cc = 2'd1;
        rc = 2'd2;
      end
    endcase
    case (kind)
      RES_UP_LEFT, RES_UP_HERE: begin
        rsel[0] = tag.row_is1 ? 2'd1 : 2'd0;
        rsel[1] = 2'd1;
        rsel[2] = 2'd2;
      end
      RES_LOW_LEFT, RES_LOW_HERE: begin
        rsel[0] = tag.row_first ? 2'd2 : 2'd1;
        rsel[1] = 2'd2;
        rsel[2] = 2'd2;
      end
      default: begin
        rsel[0] = 2'd0;
        rsel[1] = 2'd1;
        rsel[2] = 2'd2;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hsum[k] = SUM_W'(win[rsel[k]][lc]) + (SUM_W'(win[rsel[k]][cc]) <<< 1)
              + SUM_W'(win[rsel[k]][rc]);
    end
    total   = hsum[0] + (hsum[1] <<< 1) + hsum[2] + SUM_W'(ROUND_BIAS);
    blurred = SAMPLE_BITS'(total >>> NORM_SHIFT);
  end

endmodule

// File: rtl/core/clamped_3x3_gaussian_blur.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_3x3_gaussian_blur
// Raster-stream 3x3 binomial blur with edge clamping and optional mirrored
// destination indices.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in_valid/in_stall    in_sample
//   out      out_valid/out_stall  out_blurred, out_dest_index, out_run_last,
//                                 out_frame_done
//
// One item is taken per cycle while out_stall is low; the single result
// register delivers one result per cycle, so items on the last row (two
// results, four at the row end) and at row ends hold the input for the
// extra cycles. An item passes the input and window stages to the result
// register. Reset restores the configuration and empties the pipeline; the
// row stores are not cleared. in_stall reacts to out_stall in the same cycle.
// ----------------------------------------------------------------------------
`include "clamped_3x3_gaussian_blur_assert.svh"

module clamped_3x3_gaussian_blur #(
  parameter int MAX_WIDTH   = gblur_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = gblur_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gblur_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gblur_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_blurred,
  output logic [gblur_pkg::IDX_W-1:0]       out_dest_index,
  output logic                              out_run_last,
  output logic                              out_frame_done
);
  import gblur_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int AREA_W = 2 * CFG_W;

  // Configuration and derived geometry.
  logic [CFG_W-1:0]  frame_width_r;
  logic [CFG_W-1:0]  frame_height_r;
  logic              mirror_r;
  logic [CFG_W-1:0]  w_eff, h_eff;
  logic [AREA_W-1:0] area;
  logic [IDX_W-1:0]  last_idx_r;
  logic [IDX_W-1:0]  w_step_r, w_step1_r;
  logic              cfg_wr, geo_restart;

  // Input stage.
  logic                    accept_in;
  logic [COL_W-1:0]        col;
  sample_tag_t             tag;
  logic                    a_valid_r;
  logic signed [SAMPLE_BITS-1:0] a_sample_r;
  logic [COL_W-1:0]        a_col_r;
  sample_tag_t             a_tag_r;
  logic signed [SAMPLE_BITS-1:0] rd_old, rd_new;
  logic                    a_move;

  // Window stage.
  logic signed [SAMPLE_BITS-1:0] win_r [3][3];
  logic [NUM_KINDS-1:0]    pend_r, pend_nxt, pend_load, pend_rest;
  sample_tag_t             win_tag_r;
  logic [IDX_W-1:0]        base_r;
  logic                    win_mir_r;
  res_kind_t               kind;
  logic                    last_pending, emit, win_free;
  logic signed [SAMPLE_BITS-1:0] blur_val;
  logic [IDX_W-1:0]        offset, dest;

  // Result register.
  logic                    out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_blurred_r;
  logic [IDX_W-1:0]        out_dest_r;
  logic                    out_run_last_r;
  logic                    out_frame_done_r;
  logic                    out_free;

  // ---------------------------------------------------------------- config
  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign geo_restart = cfg_wr && (cfg_index == REG_FRAME_WIDTH ||
                                  cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(FRAME_WIDTH_RST);
      frame_height_r <= CFG_W'(FRAME_HEIGHT_RST);
      mirror_r       <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_MIRROR:       mirror_r       <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_r;
    end
    if (frame_height_r == '0) begin
      h_eff = CFG_W'(1);
    end else if (32'(frame_height_r) > ROW_LIMIT) begin
      h_eff = CFG_W'(ROW_LIMIT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign area = AREA_W'(w_eff) * AREA_W'(h_eff);

  // The last index is used as an item enters the window stage, the row steps
  // as its results go out. An item must not be accepted in the same cycle as
  // a configuration write, not enforced by the block, so both have settled.
  always_ff @(posedge clk) begin
    last_idx_r <= IDX_W'(area - AREA_W'(1));
    w_step_r   <= IDX_W'(w_eff);
    w_step1_r  <= IDX_W'(w_eff) + IDX_W'(1);
  end

  // ----------------------------------------------------------- input stage
  assign accept_in = in_valid && !in_stall;
  assign in_stall  = a_valid_r && !win_free;
  assign a_move    = a_valid_r && win_free;

  gblur_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (geo_restart),
    .step    (accept_in),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .col     (col),
    .tag     (tag)
  );

  gblur_linebuf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SAMPLE_BITS)
  ) u_linebuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept_in),
    .rd_addr (col),
    .wr_en   (a_move),
    .wr_addr (a_col_r),
    .wr_old  (rd_new),
    .wr_new  (a_sample_r),
    .rd_old  (rd_old),
    .rd_new  (rd_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept_in) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      a_sample_r <= in_sample;
      a_col_r    <= col;
      a_tag_r    <= tag;
    end
  end

  // ---------------------------------------------------------- window stage
  // Stale window columns and rows after a frame start are never selected
  // by the edge clamping, so the window needs no clearing.
  always_ff @(posedge clk) begin
    if (a_move) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= rd_old;
      win_r[1][2] <= rd_new;
      win_r[2][2] <= a_sample_r;
      win_tag_r   <= a_tag_r;
      win_mir_r   <= mirror_r;
      base_r      <= mirror_r ? (last_idx_r - a_tag_r.pos) : a_tag_r.pos;
    end
  end

  always_comb begin
    pend_load = '0;
    pend_load[RES_UP_LEFT]  = !a_tag_r.row_first && !a_tag_r.col_first;
    pend_load[RES_UP_HERE]  = !a_tag_r.row_first && a_tag_r.col_last;
    pend_load[RES_LOW_LEFT] = a_tag_r.row_last && !a_tag_r.col_first;
    pend_load[RES_LOW_HERE] = a_tag_r.row_last && a_tag_r.col_last;
  end

  // The lowest pending result goes out first.
  always_comb begin
    kind = RES_LOW_HERE;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        kind = res_kind_t'(2'(k));
      end
    end
  end

  assign pend_rest    = pend_r & ~(NUM_KINDS'(1) << kind);
  assign last_pending = (pend_rest == '0);
  assign out_free     = !out_valid_r || !out_stall;
  assign emit         = (pend_r != '0) && out_free;
  assign win_free     = (pend_r == '0) || (emit && last_pending);

  always_comb begin
    pend_nxt = pend_r;
    if (a_move) begin
      pend_nxt = pend_load;
    end else if (emit) begin
      pend_nxt = pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  gblur_kernel #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_kernel (
    .win     (win_r),
    .kind    (kind),
    .tag     (win_tag_r),
    .blurred (blur_val)
  );

  // Offset of the result pixel behind the current sample position.
  always_comb begin
    case (kind)
      RES_UP_LEFT:  offset = w_step1_r;
      RES_UP_HERE:  offset = w_step_r;
      RES_LOW_LEFT: offset = IDX_W'(1);
      RES_LOW_HERE: offset = '0;
      default:      offset = '0;
    endcase
  end

  assign dest = win_mir_r ? (base_r + offset) : (base_r - offset);

  // ------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_blurred_r    <= blur_val;
      out_dest_r       <= dest;
      out_run_last_r   <= last_pending;
      out_frame_done_r <= (kind == RES_LOW_HERE);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blurred    = out_blurred_r;
  assign out_dest_index = out_dest_r;
  assign out_run_last   = out_run_last_r;
  assign out_frame_done = out_frame_done_r;

  // ------------------------------------------------------------ assertions
  `GB_CHECK_SAME(a_frame_done_is_last, clk, rst_n, out_valid_r && out_frame_done_r, out_run_last_r, "frame end result is not the last result of its item")
  `GB_CHECK_NEXT(a_geo_write_restarts, clk, rst_n, geo_restart, tag.col_first && tag.row_first && (tag.pos == '0), "geometry write did not restart the raster")
  `GB_CHECK_SAME(a_first_row_silent, clk, rst_n, pend_r != '0, !(win_tag_r.row_first && !win_tag_r.row_last), "first row of a taller frame left results pending")

endmodule
